// ----- sv/gri_pkg.sv -----
// Shared types and constants for the gyro rate integrator.
package gri_pkg;

  localparam int AXES = 3;
  localparam int SUM_W = 32;
  // bias divide: reciprocal multiply in two passes per axis
  localparam int DIV_STEPS = 2;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 2'd1;

  localparam logic [15:0] RATE_SCALE_RESET = 16'd4480;
  localparam logic [22:0] DEAD_BAND_RESET = 23'd500;

  localparam logic [1:0] OP_INTEGRATE = 2'd0;
  localparam logic [1:0] OP_CALIBRATE = 2'd1;
  localparam logic [1:0] OP_ZERO = 2'd2;

  localparam logic [1:0] AXIS_FIRST = 2'd0;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef logic [1:0] axis_t;

  typedef struct packed {
    logic  load;
    axis_t axis;
    logic  mul_angle;
    logic  mul_en;
    logic  rate_en;
    logic  ang_en;
    logic  cnt_inc;
    logic  zero;
    logic  div_start;
    logic  div_step;
    logic  div_store;
    logic  cal_clear;
    logic  out_load;
  } gri_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       cal_last;
    logic       out_free;
  } gri_sts_t;

  // Clamp to the 24-bit signed rate range.
  function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sd8388607;
    lo = -34'sd8388608;
    if (v > hi) begin
      return 24'sh7FFFFF;
    end else if (v < lo) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

// ----- sv/gri_sample_if.sv -----
// Input sample channel: operation, three raw axis samples, elapsed time.
interface gri_sample_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;
  logic [15:0]        elapsed_ms;

  modport source (output valid, operation, raw_x, raw_y, raw_z, elapsed_ms, input ready);
  modport sink (input valid, operation, raw_x, raw_y, raw_z, elapsed_ms, output ready);
endinterface

// ----- sv/gri_result_if.sv -----
// Result channel: corrected rates, angles and calibration flag.
interface gri_result_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] rate_x;
  logic signed [23:0] rate_y;
  logic signed [23:0] rate_z;
  logic signed [47:0] angle_x;
  logic signed [47:0] angle_y;
  logic signed [47:0] angle_z;
  logic               calibration_done;

  modport source (output valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
                  calibration_done, input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, angle_x, angle_y, angle_z,
                calibration_done, output ready);
endinterface

// ----- sv/gri_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface gri_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [gri_pkg::CFG_IDX_W-1:0]     index;
  logic [gri_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/gyro_rate_integrator_unit.sv -----
// Top level of the gyro rate integrator: sequencer plus datapath.
//
// Each accepted sample is scaled per axis (raw * rate_scale, floored by 256), bias corrected and
// saturated to 24 bits, then integrated into the 48-bit wrapping angles when its magnitude
// reaches dead_band, accumulated toward a new bias, or used to zero the angles. The axes share
// one multiplier and are worked one after another: an integrate sample uses it twice per axis,
// any other sample once, and the calibration sample that completes the bias average then runs
// each axis's bias divide, a reciprocal multiply worked in two halves between a start state
// and a store state. Every sample yields one result beat; the result register lets the next
// sample be taken while that beat waits. Configuration writes are accepted in any cycle and
// belong to idle periods only.
module gyro_rate_integrator_unit #(
  parameter int BIAS_SAMPLES = 16
) (
  input logic          clk,
  input logic          rst,
  gri_sample_if.sink   sample,
  gri_result_if.source result,
  gri_cfg_if.sink      cfg
);
  import gri_pkg::*;

  gri_cmd_t cmd;
  gri_sts_t sts;
  logic     ready;

  assign sample.ready = ready;

  gri_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  gri_dpath #(
    .BIAS_SAMPLES (BIAS_SAMPLES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .operation  (sample.operation),
    .raw_x      (sample.raw_x),
    .raw_y      (sample.raw_y),
    .raw_z      (sample.raw_z),
    .elapsed_ms (sample.elapsed_ms),
    .cmd        (cmd),
    .sts        (sts),
    .cfg        (cfg),
    .result     (result)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample taken while one is still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result.valid || result.ready))
    else $error("result register loaded over a pending beat");

  a_cal_clears_angles: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.calibration_done |->
      result.angle_x == '0 && result.angle_y == '0 && result.angle_z == '0)
    else $error("calibration result carries nonzero angles");
`endif

endmodule

// ----- sv/gri_ctrl.sv -----
// Sequencer for the gyro integrator: walks the axes, the bias divide and the result load.
module gri_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  gri_pkg::gri_sts_t sts,
  output gri_pkg::gri_cmd_t cmd
);
  import gri_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_RATE   = 4'd2;
  localparam logic [3:0] S_AMUL   = 4'd3;
  localparam logic [3:0] S_AADD   = 4'd4;
  localparam logic [3:0] S_FIN    = 4'd5;
  localparam logic [3:0] S_DSTART = 4'd6;
  localparam logic [3:0] S_DSTEP  = 4'd7;
  localparam logic [3:0] S_DSTORE = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [3:0]        state;
  logic [3:0]        state_next;
  axis_t             axis;
  axis_t             axis_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AXIS_FIRST;
      step  <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      step  <= step_next;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.axis     = axis;
    state_next   = state;
    axis_next    = axis;
    step_next    = step;
    sample_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          axis_next  = AXIS_FIRST;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_RATE;
      end
      S_RATE: begin
        cmd.rate_en = 1'b1;
        if (sts.op == OP_INTEGRATE) begin
          state_next = S_AMUL;
        end else if (axis == AXIS_LAST) begin
          state_next = S_FIN;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_MUL;
        end
      end
      S_AMUL: begin
        cmd.mul_angle = 1'b1;
        cmd.mul_en    = 1'b1;
        state_next    = S_AADD;
      end
      S_AADD: begin
        cmd.ang_en = 1'b1;
        if (axis == AXIS_LAST) begin
          state_next = S_FIN;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_MUL;
        end
      end
      S_FIN: begin
        priority if (sts.op == OP_CALIBRATE && sts.cal_last) begin
          axis_next  = AXIS_FIRST;
          state_next = S_DSTART;
        end else if (sts.op == OP_CALIBRATE) begin
          cmd.cnt_inc = 1'b1;
          state_next  = S_OUT;
        end else if (sts.op == OP_ZERO) begin
          cmd.zero   = 1'b1;
          state_next = S_OUT;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        step_next     = '0;
        state_next    = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_DSTORE;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (axis == AXIS_LAST) begin
          cmd.cal_clear = 1'b1;
          state_next    = S_OUT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_DSTART;
        end
      end
      S_OUT: begin
        // hold until the result register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/gri_dpath.sv -----
// Datapath: config registers, shared multiplier, bias divider, angle state and result register.
module gri_dpath #(
  parameter int BIAS_SAMPLES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         operation,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic signed [15:0] raw_z,
  input  logic [15:0]        elapsed_ms,
  input  gri_pkg::gri_cmd_t  cmd,
  output gri_pkg::gri_sts_t  sts,
  gri_cfg_if.sink            cfg,
  gri_result_if.source       result
);
  import gri_pkg::*;

  localparam int CNT_W = $clog2(BIAS_SAMPLES + 1);
  localparam logic [CNT_W-1:0] DIVISOR = CNT_W'(BIAS_SAMPLES);

  // Reciprocal that gives an exact floor(n / BIAS_SAMPLES) for any 32-bit magnitude n.
  localparam int DIV_SHIFT = SUM_W + $clog2(BIAS_SAMPLES);
  localparam int ACC_W = 2 * SUM_W + 1;
  localparam int RECIP_W = SUM_W + 1;
  localparam int LO_W = 17;
  localparam int PART_W = SUM_W + LO_W;
  localparam logic [ACC_W-1:0] DIV_POW = ACC_W'(1) << DIV_SHIFT;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'((DIV_POW + ACC_W'(BIAS_SAMPLES - 1)) / ACC_W'(BIAS_SAMPLES));
  localparam logic [RECIP_W-LO_W-1:0] RECIP_HI = DIV_RECIP[RECIP_W-1:LO_W];
  localparam logic [LO_W-1:0] RECIP_LO = DIV_RECIP[LO_W-1:0];

  logic [15:0]        rate_scale;
  logic [22:0]        dead_band;

  logic [1:0]         op_q;
  logic signed [15:0] raw_q [AXES];
  logic [15:0]        elapsed_q;

  logic signed [23:0] rate_q [AXES];
  logic signed [23:0] bias [AXES];
  logic signed [47:0] angle [AXES];
  logic [SUM_W-1:0]   cal_sum [AXES];
  logic [CNT_W-1:0]   cal_count;
  logic               done_q;

  logic signed [40:0] prod_q;
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;

  logic signed [23:0] unc;
  logic signed [23:0] rate_new;
  logic signed [23:0] rate_cur;
  logic [23:0]        rate_mag;
  logic               above_band;

  logic               div_neg;
  logic               div_hi;
  logic [SUM_W-1:0]   div_mag;
  logic [LO_W-1:0]    div_coef;
  logic [PART_W-1:0]  div_part;
  logic [ACC_W-1:0]   div_acc;
  logic [ACC_W-1:0]   div_shifted;
  logic [SUM_W-1:0]   div_quo;
  logic [SUM_W-1:0]   sum_cur;
  logic signed [33:0] quo_signed;

  logic               out_valid;

  // Configuration registers; writes must land only while idle, which the block never checks.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale <= RATE_SCALE_RESET;
      dead_band  <= DEAD_BAND_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_RATE_SCALE) begin
        rate_scale <= cfg.data[15:0];
      end
      if (cfg.index == REG_DEAD_BAND) begin
        dead_band <= cfg.data[22:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= operation;
      raw_q[0]  <= raw_x;
      raw_q[1]  <= raw_y;
      raw_q[2]  <= raw_z;
      elapsed_q <= elapsed_ms;
    end
  end

  // Shared multiplier: raw * scale, then rate * elapsed.
  assign rate_cur = rate_q[cmd.axis];
  assign mul_a = cmd.mul_angle ? rate_cur : {{8{raw_q[cmd.axis][15]}}, raw_q[cmd.axis]};
  assign mul_b = cmd.mul_angle ? $signed({1'b0, elapsed_q}) : $signed({1'b0, rate_scale});

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // Arithmetic shift by eight floors the scaled product.
  assign unc = prod_q[31:0] >>> 8 == '0 ? 24'sd0 : prod_q[31:8];
  assign rate_new = sat24(34'(unc) - 34'(bias[cmd.axis]));

  always_ff @(posedge clk) begin
    if (cmd.rate_en) begin
      rate_q[cmd.axis] <= rate_new;
    end
  end

  assign rate_mag   = rate_cur[23] ? 24'(-rate_cur) : 24'(rate_cur);
  assign above_band = rate_mag >= {1'b0, dead_band};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        angle[i] <= '0;
      end
    end else if (cmd.zero || cmd.cal_clear) begin
      for (int i = 0; i < AXES; i++) begin
        angle[i] <= '0;
      end
    end else if (cmd.ang_en && above_band) begin
      angle[cmd.axis] <= angle[cmd.axis] + {{7{prod_q[40]}}, prod_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        cal_sum[i] <= '0;
      end
      cal_count <= '0;
    end else if (cmd.cal_clear) begin
      for (int i = 0; i < AXES; i++) begin
        cal_sum[i] <= '0;
      end
      cal_count <= '0;
    end else begin
      if (cmd.rate_en && op_q == OP_CALIBRATE) begin
        cal_sum[cmd.axis] <= cal_sum[cmd.axis] + SUM_W'(unc);
      end
      if (cmd.cnt_inc) begin
        cal_count <= cal_count + 1'b1;
      end
    end
  end

  // Divide the sum magnitude by multiplying with the reciprocal, upper half first, then
  // shift the product down; the sign is put back so the quotient truncates toward zero.
  assign sum_cur     = cal_sum[cmd.axis];
  assign div_coef    = div_hi ? {1'b0, RECIP_HI} : RECIP_LO;
  assign div_part    = PART_W'(div_mag) * PART_W'(div_coef);
  assign div_shifted = div_acc >> DIV_SHIFT;
  assign div_quo     = div_shifted[SUM_W-1:0];
  assign quo_signed  = div_neg ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= sum_cur[SUM_W-1];
      div_mag <= sum_cur[SUM_W-1] ? -sum_cur : sum_cur;
      div_hi  <= 1'b1;
      div_acc <= '0;
    end else if (cmd.div_step) begin
      div_hi  <= 1'b0;
      div_acc <= (div_acc << LO_W) + ACC_W'(div_part);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        bias[i] <= '0;
      end
    end else if (cmd.div_store) begin
      bias[cmd.axis] <= sat24(quo_signed);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else if (cmd.load) begin
      done_q <= 1'b0;
    end else if (cmd.cal_clear) begin
      done_q <= 1'b1;
    end
  end

  // Result register: frees the sequencer while a beat waits downstream.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.rate_x           <= rate_q[0];
      result.rate_y           <= rate_q[1];
      result.rate_z           <= rate_q[2];
      result.angle_x          <= angle[0];
      result.angle_y          <= angle[1];
      result.angle_z          <= angle[2];
      result.calibration_done <= done_q;
    end
  end

  assign result.valid = out_valid;

  assign sts.op       = op_q;
  assign sts.cal_last = ({1'b0, cal_count} + 1'b1) >= {1'b0, DIVISOR};
  assign sts.out_free = !out_valid || result.ready;

endmodule

// ----- test/tb_gyro_rate_integrator_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for gyro_rate_integrator_unit: predicted angle beats vs. DUT output.
module tb_gyro_rate_integrator_unit;
  import gri_pkg::*;

  localparam int BIAS_SAMPLES = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 120;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [AXES-1:0][23:0] rate;
    logic [AXES-1:0][47:0] angle;
    logic                  done;
  } angle_beat_t;

  class gri_angle_tracker;
    logic [15:0]    scale;
    logic [22:0]    dead_band;
    longint         bias [AXES];
    logic [47:0]    angle [AXES];
    logic [31:0]    cal_sum [AXES];
    int unsigned    cal_count;
    angle_beat_t    awaited [$];
    int unsigned    failures;
    string          axis_tag [AXES] = '{"x", "y", "z"};

    function new();
      scale = RATE_SCALE_RESET;
      dead_band = DEAD_BAND_RESET;
      for (int i = 0; i < AXES; i++) begin
        bias[i] = 0;
        angle[i] = '0;
        cal_sum[i] = '0;
      end
      cal_count = 0;
      failures = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RATE_SCALE: scale = data[15:0];
        REG_DEAD_BAND: dead_band = data[22:0];
        default: ;
      endcase
    endfunction

    static function longint clamp_rate(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function void take_sample(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic [15:0] elapsed);
      longint      raw [AXES];
      longint      unc [AXES];
      longint      rate [AXES];
      longint      mag;
      angle_beat_t beat;
      raw[0] = x;
      raw[1] = y;
      raw[2] = z;
      beat.done = 1'b0;
      for (int i = 0; i < AXES; i++) begin
        // floor division by 256 through the arithmetic shift
        unc[i] = (raw[i] * longint'(scale)) >>> 8;
        rate[i] = clamp_rate(unc[i] - bias[i]);
      end
      case (op)
        OP_INTEGRATE: begin
          for (int i = 0; i < AXES; i++) begin
            mag = (rate[i] < 0) ? -rate[i] : rate[i];
            if (mag >= longint'(dead_band)) begin
              angle[i] = angle[i] + 48'(rate[i] * longint'(elapsed));
            end
          end
        end
        OP_CALIBRATE: begin
          for (int i = 0; i < AXES; i++) begin
            cal_sum[i] = cal_sum[i] + 32'(unc[i]);
          end
          cal_count++;
          if (cal_count >= BIAS_SAMPLES) begin
            // signed divide truncates toward zero
            for (int i = 0; i < AXES; i++) begin
              bias[i] = clamp_rate(longint'($signed(cal_sum[i])) / BIAS_SAMPLES);
              cal_sum[i] = '0;
              angle[i] = '0;
            end
            cal_count = 0;
            beat.done = 1'b1;
          end
        end
        OP_ZERO: begin
          for (int i = 0; i < AXES; i++) begin
            angle[i] = '0;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < AXES; i++) begin
        beat.rate[i] = 24'(rate[i]);
        beat.angle[i] = angle[i];
      end
      awaited.push_back(beat);
    endfunction

    function void check_result(logic [AXES-1:0][23:0] rate, logic [AXES-1:0][47:0] ang,
                               logic done);
      angle_beat_t beat;
      if (awaited.size() == 0) begin
        $error("result beat with no sample awaiting it");
        failures++;
        return;
      end
      beat = awaited.pop_front();
      for (int i = 0; i < AXES; i++) begin
        if (rate[i] !== beat.rate[i]) begin
          $error("rate_%s expected %0d got %0d", axis_tag[i], $signed(beat.rate[i]),
                 $signed(rate[i]));
          failures++;
        end
        if (ang[i] !== beat.angle[i]) begin
          $error("angle_%s expected %0d got %0d", axis_tag[i], $signed(beat.angle[i]),
                 $signed(ang[i]));
          failures++;
        end
      end
      if (done !== beat.done) begin
        $error("calibration_done expected %0b got %0b", beat.done, done);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_on;
  int unsigned result_hold;
  gri_angle_tracker book;

  gri_sample_if sample_bus ();
  gri_result_if result_bus ();
  gri_cfg_if    cfg_bus ();

  gyro_rate_integrator_unit #(
    .BIAS_SAMPLES(BIAS_SAMPLES)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #4_000_000;
    $display("tb_gyro_rate_integrator_unit: errors");
    $finish;
  end

  // Result side: check each beat, stall in random bursts while idle_on is set.
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      book.check_result({result_bus.rate_z, result_bus.rate_y, result_bus.rate_x},
                        {result_bus.angle_z, result_bus.angle_y, result_bus.angle_x},
                        result_bus.calibration_done);
    end
    if (result_hold != 0) begin
      result_hold <= result_hold - 1;
      result_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      result_hold <= $urandom_range(0, 13);
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 127)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] near_raw(logic signed [15:0] base);
    return ($urandom_range(0, 2) != 0) ? base : pick_raw();
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 50));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [1:0] op, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic [15:0] elapsed);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.operation <= op;
    sample_bus.raw_x <= x;
    sample_bus.raw_y <= y;
    sample_bus.raw_z <= z;
    sample_bus.elapsed_ms <= elapsed;
    do @(posedge clk); while (!sample_bus.ready);
    book.take_sample(op, x, y, z, elapsed);
  endtask

  // Drop valid and hold until every predicted beat has come back.
  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(logic [15:0] scale, logic [22:0] dead_band);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_RATE_SCALE;
    cfg_bus.data <= CFG_DATA_W'(scale);
    do @(posedge clk); while (!cfg_bus.ready);
    book.write_register(REG_RATE_SCALE, CFG_DATA_W'(scale));
    cfg_bus.index <= REG_DEAD_BAND;
    cfg_bus.data <= CFG_DATA_W'(dead_band);
    do @(posedge clk); while (!cfg_bus.ready);
    book.write_register(REG_DEAD_BAND, CFG_DATA_W'(dead_band));
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    int unsigned       issued;
    int unsigned       kind;
    int unsigned       burst;
    logic signed [15:0] base [AXES];
    issued = 0;
    while (issued < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_sample(OP_INTEGRATE, pick_raw(), pick_raw(), pick_raw(),
                                   pick_elapsed());
      end else if (kind <= 7) begin
        // calibration run around a steady base, as a sensor at rest would give
        burst = $urandom_range(1, 16);
        for (int i = 0; i < AXES; i++) base[i] = pick_raw();
        repeat (burst) send_sample(OP_CALIBRATE, near_raw(base[0]), near_raw(base[1]),
                                   near_raw(base[2]), pick_elapsed());
      end else begin
        burst = 1;
        send_sample((kind == 8) ? OP_ZERO : OP_UNUSED, pick_raw(), pick_raw(), pick_raw(),
                    pick_elapsed());
      end
      issued += burst;
    end
  endtask

  task automatic run_phase(logic [15:0] scale, logic [22:0] dead_band, int unsigned count);
    drain_results();
    set_registers(scale, dead_band);
    run_random(count);
  endtask

  initial begin
    book = new();
    rst = 1'b1;
    idle_on = 1'b1;
    result_hold = 0;
    result_bus.ready = 1'b0;
    sample_bus.valid = 1'b0;
    sample_bus.operation = OP_INTEGRATE;
    sample_bus.raw_x = '0;
    sample_bus.raw_y = '0;
    sample_bus.raw_z = '0;
    sample_bus.elapsed_ms = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_RATE_SCALE;
    cfg_bus.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed beats under the reset register values
    send_sample(OP_INTEGRATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF);
    send_sample(OP_INTEGRATE, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF);
    send_sample(OP_INTEGRATE, 16'sd0, 16'sd28, -16'sd29, 16'd1000);
    send_sample(OP_INTEGRATE, 16'sd1234, -16'sd5678, 16'sd16384, 16'd0);
    send_sample(OP_UNUSED, 16'sd100, -16'sd100, 16'sd7, 16'd77);
    send_sample(OP_ZERO, 16'sh7FFF, -16'sd1, 16'sd1, 16'hFFFF);
    for (int k = 0; k < BIAS_SAMPLES / 2; k++) begin
      send_sample(OP_CALIBRATE, 16'(200 + k), 16'(-300 - 7 * k),
                  k[0] ? 16'sh7FFF : 16'sh8000, 16'(k));
    end
    // integrate and zero in the middle of a calibration leave its sums alone
    send_sample(OP_INTEGRATE, 16'sd3000, -16'sd3000, 16'sd50, 16'd500);
    send_sample(OP_ZERO, 16'sd1, 16'sd2, 16'sd3, 16'd4);
    for (int k = BIAS_SAMPLES / 2; k < BIAS_SAMPLES; k++) begin
      send_sample(OP_CALIBRATE, 16'(200 + k), 16'(-300 - 7 * k),
                  k[0] ? 16'sh7FFF : 16'sh8000, 16'(k));
    end
    send_sample(OP_INTEGRATE, 16'sd200, -16'sd300, 16'sd0, 16'd250);

    run_phase(16'hFFFF, 23'd0, 220);
    run_phase(16'd0, 23'h7FFFFF, 120);
    run_phase(16'($urandom), 23'($urandom_range(0, 30000)), 250);
    run_phase(RATE_SCALE_RESET, DEAD_BAND_RESET, 240);
    run_phase(16'($urandom), 23'($urandom_range(0, 8388607)), 120);

    // closing stretch at full rate on both sides
    drain_results();
    idle_on = 1'b0;
    set_registers(16'($urandom), 23'($urandom_range(0, 2000)));
    run_random(150);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.failures == 0) begin
      $display("tb_gyro_rate_integrator_unit: clean");
    end else begin
      $display("tb_gyro_rate_integrator_unit: errors");
    end
    $finish;
  end

endmodule
